// ===== src/rcg_pkg.sv =====
// Shared constants, register map and types for the rotated checkerboard color generator.
// Used by the top level, the floor divider and the port checker; depends on nothing.
package rcg_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_COLORS_DEF  = 8;

    localparam int CELL_W     = 13;  // cell size, unsigned Q9.4
    localparam int TRIG_W     = 16;  // cosine and sine, signed Q1.14
    localparam int CELL_SHIFT = 10;  // aligns Q.14 products to the Q.4 cell size
    localparam int COUNT_W    = 4;
    localparam int IDX_W      = 3;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int PAIR_W     = 2 * COLOR_W;
    localparam int NUM_PAIRS  = 4;
    localparam int NUM_AXES   = 2;
    localparam int MOD_STEP   = 8;   // sum bits folded into the remainder per stage

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int REG_LSB = 3;      // registers sit on 8-byte boundaries

    localparam int MIN_COUNT     = 2;
    localparam int DEFAULT_COUNT = 3;

    localparam logic [CELL_W-1:0]  RST_CELL_SIZE = CELL_W'(800);
    localparam logic [2*TRIG_W-1:0] RST_COS_SIN  = (2*TRIG_W)'(16384);
    localparam logic [COUNT_W-1:0] RST_COUNT     = COUNT_W'(DEFAULT_COUNT);
    localparam logic [CHAN_W-1:0]  RST_ALPHA     = CHAN_W'(255);

    typedef enum logic [PADDR_W-REG_LSB-1:0] {
        REG_CELL_SIZE  = 3'd0,
        REG_COS_SIN    = 3'd1,
        REG_PAL_COUNT  = 3'd2,
        REG_FILL_ALPHA = 3'd3,
        REG_PAIR_A     = 3'd4,
        REG_PAIR_B     = 3'd5,
        REG_PAIR_C     = 3'd6,
        REG_PAIR_D     = 3'd7
    } t_reg_idx;

endpackage

// ===== src/rotated_checkerboard_color_generator.sv =====
// Top level of the rotated checkerboard color generator: config registers, rotation,
// palette modulo and output buffering. Depends on rcg_pkg and rcg_floor_div.
//
// One pixel coordinate enters per clock cycle and one colored pixel leaves per cycle
// while the output keeps accepting. The pipeline has two stages for the multiply and add
// of the rotation, COORD_WIDTH + 8 stages in the floor divider that produces one quotient
// bit per stage, one stage for the index sum, one modulo stage per eight sum bits, and the
// output register. While the output is stalled the stages keep moving until a finished
// item lands in the skid register behind the pipeline; only then does the input stop
// accepting, until the output drains.
// Configuration goes through the APB port (8-byte register spacing) and must only be
// written while no item is in flight.
module rotated_checkerboard_color_generator
    import rcg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int MAX_COLORS  = MAX_COLORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pixel_x,
    input  logic signed [COORD_WIDTH-1:0] i_pixel_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [CHAN_W-1:0]             o_red,
    output logic [CHAN_W-1:0]             o_green,
    output logic [CHAN_W-1:0]             o_blue,
    output logic [CHAN_W-1:0]             o_alpha,
    output logic [IDX_W-1:0]              o_palette_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);

    localparam int PROD_W  = COORD_WIDTH + TRIG_W;
    localparam int ROT_W   = PROD_W + 1;
    localparam int NUM_W   = ROT_W - CELL_SHIFT;
    localparam int SUM_W   = NUM_W + 1;
    localparam int NMOD    = (SUM_W + MOD_STEP - 1) / MOD_STEP;
    localparam int MOD_PAD = NMOD * MOD_STEP;
    localparam logic [COUNT_W-1:0] FALLBACK_COUNT =
        COUNT_W'((DEFAULT_COUNT <= MAX_COLORS) ? DEFAULT_COUNT : MAX_COLORS);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [IDX_W-1:0]  idx;
    } t_pixel;

    // ---------------- configuration registers ----------------
    logic [CELL_W-1:0]   r_cell_size;
    logic [2*TRIG_W-1:0] r_cos_sin;
    logic [COUNT_W-1:0]  r_pal_count;
    logic [CHAN_W-1:0]   r_fill_alpha;
    logic [PAIR_W-1:0]   r_pair [NUM_PAIRS];
    t_reg_idx            w_reg;
    logic                w_wr;

    assign w_reg  = t_reg_idx'(paddr[PADDR_W-1:REG_LSB]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size  <= RST_CELL_SIZE;
            r_cos_sin    <= RST_COS_SIN;
            r_pal_count  <= RST_COUNT;
            r_fill_alpha <= RST_ALPHA;
            for (int k = 0; k < NUM_PAIRS; k++) begin
                r_pair[k] <= '0;
            end
        end else if (w_wr) begin
            case (w_reg)
                REG_CELL_SIZE:  r_cell_size  <= pwdata[CELL_W-1:0];
                REG_COS_SIN:    r_cos_sin    <= pwdata[2*TRIG_W-1:0];
                REG_PAL_COUNT:  r_pal_count  <= pwdata[COUNT_W-1:0];
                REG_FILL_ALPHA: r_fill_alpha <= pwdata[CHAN_W-1:0];
                REG_PAIR_A:     r_pair[0]    <= pwdata[PAIR_W-1:0];
                REG_PAIR_B:     r_pair[1]    <= pwdata[PAIR_W-1:0];
                REG_PAIR_C:     r_pair[2]    <= pwdata[PAIR_W-1:0];
                REG_PAIR_D:     r_pair[3]    <= pwdata[PAIR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_CELL_SIZE:  prdata = PDATA_W'(r_cell_size);
            REG_COS_SIN:    prdata = PDATA_W'(r_cos_sin);
            REG_PAL_COUNT:  prdata = PDATA_W'(r_pal_count);
            REG_FILL_ALPHA: prdata = PDATA_W'(r_fill_alpha);
            REG_PAIR_A:     prdata = PDATA_W'(r_pair[0]);
            REG_PAIR_B:     prdata = PDATA_W'(r_pair[1]);
            REG_PAIR_C:     prdata = PDATA_W'(r_pair[2]);
            REG_PAIR_D:     prdata = PDATA_W'(r_pair[3]);
            default:        prdata = '0;
        endcase
    end

    // A zero cell size counts as one sixteenth of a pixel, and an unusable palette
    // count falls back to three colors, or to MAX_COLORS if that is fewer.
    logic [CELL_W-1:0]  w_size;
    logic [COUNT_W-1:0] w_count;
    logic signed [TRIG_W-1:0] w_cos;
    logic signed [TRIG_W-1:0] w_sin;

    assign w_size  = (r_cell_size == '0) ? CELL_W'(1) : r_cell_size;
    assign w_count = (r_pal_count < COUNT_W'(MIN_COUNT) || r_pal_count > COUNT_W'(MAX_COLORS))
                     ? FALLBACK_COUNT : r_pal_count;
    assign w_cos   = signed'(r_cos_sin[TRIG_W-1:0]);
    assign w_sin   = signed'(r_cos_sin[2*TRIG_W-1:TRIG_W]);

    // ---------------- pipeline ----------------
    logic w_en;
    logic r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_xc;
    logic signed [PROD_W-1:0] r_ys;
    logic signed [PROD_W-1:0] r_xs;
    logic signed [PROD_W-1:0] r_yc;
    logic signed [PROD_W-1:0] w_xc;
    logic signed [PROD_W-1:0] w_ys;
    logic signed [PROD_W-1:0] w_xs;
    logic signed [PROD_W-1:0] w_yc;
    logic signed [ROT_W-1:0]  r_rx;
    logic signed [ROT_W-1:0]  r_ry;

    assign w_xc = i_pixel_x * w_cos;
    assign w_ys = i_pixel_y * w_sin;
    assign w_xs = i_pixel_x * w_sin;
    assign w_yc = i_pixel_y * w_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xc <= w_xc;
            r_ys <= w_ys;
            r_xs <= w_xs;
            r_yc <= w_yc;
            r_rx <= ROT_W'(r_xc) - ROT_W'(r_ys);
            r_ry <= ROT_W'(r_xs) + ROT_W'(r_yc);
        end
    end

    // Dropping the low bits is an exact floor by 1024, so only the cell size is left
    // to divide by.
    logic [NUM_W-1:0] w_num  [NUM_AXES];
    logic [NUM_W-1:0] w_quot [NUM_AXES];
    logic             w_div_valid;

    assign w_num[0] = r_rx[ROT_W-1:CELL_SHIFT];
    assign w_num[1] = r_ry[ROT_W-1:CELL_SHIFT];

    rcg_floor_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_num   (w_num),
        .i_den   (w_size),
        .o_valid (w_div_valid),
        .o_quot  (w_quot)
    );

    // Sum of the cell indices, then its remainder by the palette count, folded in
    // eight bits per stage, most significant first.
    logic [NMOD:0]        r_mv;
    logic [MOD_PAD-1:0]   r_ms [NMOD];
    logic [IDX_W-1:0]     r_mr [NMOD+1];
    logic [IDX_W-1:0]     n_mr [NMOD+1];

    always_comb begin
        logic [IDX_W:0] v_t;
        logic [IDX_W-1:0] v_r;
        n_mr[0] = '0;
        for (int k = 0; k < NMOD; k++) begin
            v_r = r_mr[k];
            for (int b = 0; b < MOD_STEP; b++) begin
                v_t = {v_r, r_ms[k][MOD_PAD-1-b]};
                if (v_t >= w_count) begin
                    v_t = v_t - w_count;
                end
                v_r = v_t[IDX_W-1:0];
            end
            n_mr[k+1] = v_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (w_en) begin
            r_mv <= {r_mv[NMOD-1:0], w_div_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ms[0] <= MOD_PAD'({1'b0, w_quot[0]} + {1'b0, w_quot[1]});
            for (int k = 1; k < NMOD; k++) begin
                r_ms[k] <= r_ms[k-1] << MOD_STEP;
            end
            r_mr[0] <= n_mr[0];
            for (int k = 1; k <= NMOD; k++) begin
                r_mr[k] <= n_mr[k];
            end
        end
    end

    // ---------------- palette lookup and output buffering ----------------
    t_pixel             w_pix;
    logic [IDX_W-1:0]   w_idx;
    logic [PAIR_W-1:0]  w_pair;
    logic [COLOR_W-1:0] w_color;

    assign w_idx   = r_mr[NMOD];
    assign w_pair  = r_pair[w_idx[IDX_W-1:1]];
    assign w_color = w_idx[0] ? w_pair[PAIR_W-1:COLOR_W] : w_pair[COLOR_W-1:0];

    assign w_pix.red   = w_color[3*CHAN_W-1:2*CHAN_W];
    assign w_pix.green = w_color[2*CHAN_W-1:CHAN_W];
    assign w_pix.blue  = w_color[CHAN_W-1:0];
    assign w_pix.alpha = r_fill_alpha;
    assign w_pix.idx   = w_idx;

    t_pixel r_out;
    t_pixel r_skid;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_mv[NMOD]) begin
            if (w_out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_free) begin
                r_out <= r_skid;
            end
        end else if (r_mv[NMOD]) begin
            if (w_out_free) begin
                r_out <= w_pix;
            end else begin
                r_skid <= w_pix;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_red           = r_out.red;
    assign o_green         = r_out.green;
    assign o_blue          = r_out.blue;
    assign o_alpha         = r_out.alpha;
    assign o_palette_index = r_out.idx;

endmodule

// ===== src/rcg_floor_div.sv =====
// Pipelined floor divider for the two rotated axes: one quotient bit per stage.
// Returns |floor(num / den)| for each axis; depends on rcg_pkg.
module rcg_floor_div
    import rcg_pkg::*;
#(
    parameter int NUM_W = COORD_WIDTH_DEF + 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num [NUM_AXES],
    input  logic [CELL_W-1:0] i_den,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot [NUM_AXES]
);

    localparam int QW  = NUM_W - 1;
    localparam int NST = QW + 1;

    logic [QW-1:0]     r_acc [NUM_AXES][NST];
    logic [QW-1:0]     n_acc [NUM_AXES][NST];
    logic [CELL_W-1:0] r_rem [NUM_AXES][NST-1];
    logic [CELL_W-1:0] n_rem [NUM_AXES][NST-1];
    logic              r_neg [NUM_AXES][NST];
    logic              n_neg [NUM_AXES][NST];
    logic [NST:0]      r_vld;
    logic [NUM_W-1:0]  r_quot [NUM_AXES];

    // A negative numerator n is divided as ~n = -n-1; its floor magnitude is then
    // the quotient of ~n plus one, added at the output stage.
    always_comb begin
        logic [CELL_W:0] v_t;
        logic [CELL_W:0] v_d;
        logic            v_ge;
        for (int l = 0; l < NUM_AXES; l++) begin
            n_acc[l][0] = i_num[l][NUM_W-1] ? ~i_num[l][QW-1:0] : i_num[l][QW-1:0];
            n_neg[l][0] = i_num[l][NUM_W-1];
            n_rem[l][0] = '0;
            for (int j = 1; j < NST; j++) begin
                v_t  = {r_rem[l][j-1], r_acc[l][j-1][QW-1]};
                v_d  = v_t - {1'b0, i_den};
                v_ge = (v_t >= {1'b0, i_den});
                n_acc[l][j] = {r_acc[l][j-1][QW-2:0], v_ge};
                n_neg[l][j] = r_neg[l][j-1];
                if (j < NST - 1) begin
                    n_rem[l][j] = v_ge ? v_d[CELL_W-1:0] : v_t[CELL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_neg <= n_neg;
            for (int l = 0; l < NUM_AXES; l++) begin
                r_quot[l] <= {1'b0, r_acc[l][NST-1]} + NUM_W'(r_neg[l][NST-1]);
            end
        end
    end

    assign o_valid = r_vld[NST];
    assign o_quot  = r_quot;

endmodule

// ===== src/rcg_checker.sv =====
// Port-level checker for the rotated checkerboard color generator, bound to the top level.
// Depends on rcg_pkg and on the top level's port list.
module rcg_checker
    import rcg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int MAX_COLORS  = MAX_COLORS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [COORD_WIDTH-1:0] i_pixel_x,
    input logic [COORD_WIDTH-1:0] i_pixel_y,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [CHAN_W-1:0]      o_red,
    input logic [CHAN_W-1:0]      o_green,
    input logic [CHAN_W-1:0]      o_blue,
    input logic [CHAN_W-1:0]      o_alpha,
    input logic [IDX_W-1:0]       o_palette_index
);

    // Reset empties the output and the skid register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty after reset");

    // A stalled item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_red) && $stable(o_green) && $stable(o_blue)
            && $stable(o_alpha) && $stable(o_palette_index))
        else $error("stalled output item changed");

    // The input side only backs up while a finished item waits at the output.
    a_backpressure_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output");

    // An offered item waits with its coordinate unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid
            && $stable(i_pixel_x) && $stable(i_pixel_y))
        else $error("waiting input item changed");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_palette_index) < MAX_COLORS))
        else $error("palette index beyond the palette");

endmodule

bind rotated_checkerboard_color_generator rcg_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_COLORS  (MAX_COLORS)
) u_rcg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_pixel_x       (i_pixel_x),
    .i_pixel_y       (i_pixel_y),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_red           (o_red),
    .o_green         (o_green),
    .o_blue          (o_blue),
    .o_alpha         (o_alpha),
    .o_palette_index (o_palette_index)
);

// ===== test/tb_rotated_checkerboard_color_generator.sv =====
// Testbench for the rotated checkerboard color generator: drives pixel coordinates, predicts
// each colored pixel from a local copy of the registers and checks every result in order.
// Depends on rcg_pkg and the top level rotated_checkerboard_color_generator.
module tb_rotated_checkerboard_color_generator;
    import rcg_pkg::*;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int ITEMS_PER_SETTING  = 120;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [IDX_W-1:0]  index;
    } t_pixel_color;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [COORD_W-1:0] i_pixel_x = '0;
    logic signed [COORD_W-1:0] i_pixel_y = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [CHAN_W-1:0]         o_red, o_green, o_blue, o_alpha;
    logic [IDX_W-1:0]          o_palette_index;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // Local copy of the register file, kept in step with every write.
    logic [CELL_W-1:0]   cell_size_q = RST_CELL_SIZE;
    logic [2*TRIG_W-1:0] cos_sin_q   = RST_COS_SIN;
    logic [COUNT_W-1:0]  pal_count_q = RST_COUNT;
    logic [CHAN_W-1:0]   alpha_q     = RST_ALPHA;
    logic [PAIR_W-1:0]   pairs_q [NUM_PAIRS] = '{default: '0};

    t_pixel_color expected_colors [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    rotated_checkerboard_color_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue), .o_alpha(o_alpha),
        .o_palette_index(o_palette_index),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Floor of n / d for d > 0, returned as a magnitude.
    function automatic longint cell_magnitude(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return (q < 0) ? -q : q;
    endfunction

    function automatic t_pixel_color predict_color(input logic signed [COORD_W-1:0] x,
                                                   input logic signed [COORD_W-1:0] y);
        longint            c, s, rx, ry, den, count, sum;
        logic [IDX_W-1:0]  index_v;
        logic [PAIR_W-1:0] pair_v;
        logic [COLOR_W-1:0] color_v;
        t_pixel_color      result;
        c = longint'($signed(cos_sin_q[TRIG_W-1:0]));
        s = longint'($signed(cos_sin_q[2*TRIG_W-1:TRIG_W]));
        rx = longint'(x) * c - longint'(y) * s;
        ry = longint'(x) * s + longint'(y) * c;
        // A zero cell size behaves as the smallest cell, one sixteenth of a pixel.
        den = longint'((cell_size_q == '0) ? CELL_W'(1) : cell_size_q) << CELL_SHIFT;
        count = longint'(pal_count_q);
        if (count < MIN_COUNT || count > MAX_COLORS_DEF)
            count = DEFAULT_COUNT;
        sum = cell_magnitude(rx, den) + cell_magnitude(ry, den);
        index_v = IDX_W'(sum % count);
        pair_v = pairs_q[index_v[2:1]];
        color_v = index_v[0] ? pair_v[PAIR_W-1:COLOR_W] : pair_v[COLOR_W-1:0];
        result.red   = color_v[23:16];
        result.green = color_v[15:8];
        result.blue  = color_v[7:0];
        result.alpha = alpha_q;
        result.index = index_v;
        return result;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge i_clk) begin
        t_pixel_color got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{red: o_red, green: o_green, blue: o_blue, alpha: o_alpha,
                    index: o_palette_index};
            if (expected_colors.size() == 0) begin
                $error("pixel result with no item outstanding");
                fail_count++;
            end else begin
                want = expected_colors.pop_front();
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
                check_field("alpha", want.alpha, got.alpha);
                check_field("palette_index", want.index, got.index);
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_CELL_SIZE:  cell_size_q = value[CELL_W-1:0];
            REG_COS_SIN:    cos_sin_q   = value[2*TRIG_W-1:0];
            REG_PAL_COUNT:  pal_count_q = value[COUNT_W-1:0];
            REG_FILL_ALPHA: alpha_q     = value[CHAN_W-1:0];
            REG_PAIR_A:     pairs_q[0]  = value[PAIR_W-1:0];
            REG_PAIR_B:     pairs_q[1]  = value[PAIR_W-1:0];
            REG_PAIR_C:     pairs_q[2]  = value[PAIR_W-1:0];
            REG_PAIR_D:     pairs_q[3]  = value[PAIR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        expected_colors.push_back(predict_color(x, y));
    endtask

    // Holds the input back until every pixel in flight has come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        if ($urandom_range(1))
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(1023)) - 512);
    endfunction

    function automatic logic [PDATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic write_palette(input logic [PDATA_W-1:0] a, input logic [PDATA_W-1:0] b,
                                 input logic [PDATA_W-1:0] c, input logic [PDATA_W-1:0] d);
        write_reg(REG_PAIR_A, a);
        write_reg(REG_PAIR_B, b);
        write_reg(REG_PAIR_C, c);
        write_reg(REG_PAIR_D, d);
    endtask

    task automatic test_reset_values();
        send_pixel(0, 0);
        send_pixel(-1, -1);
        send_pixel(32767, -32768);
        wait_idle();
    endtask

    task automatic test_coordinate_extremes();
        write_palette(64'h0000_2233_4411_0000, 64'h0000_5566_7788_9900,
                      64'h0000_AABB_CCDD_EEFF, 64'h0000_FFFF_FF01_0203);
        write_reg(REG_PAL_COUNT, 8);
        write_reg(REG_CELL_SIZE, 160);
        write_reg(REG_FILL_ALPHA, 8'h5A);
        // Sine at -2.0 and cosine just under +2.0 give the largest products.
        write_reg(REG_COS_SIN, 64'h8000_7FFF);
        send_pixel(32767, 32767);
        send_pixel(-32768, -32768);
        send_pixel(32767, -32768);
        send_pixel(-32768, 32767);
        send_pixel(0, 0);
        wait_idle();
    endtask

    task automatic test_zero_cell_size();
        write_reg(REG_COS_SIN, 64'h0000_4000);
        write_reg(REG_CELL_SIZE, 0);
        send_pixel(3, -2);
        send_pixel(-32768, 5);
        send_pixel(0, -1);
        wait_idle();
    endtask

    task automatic test_palette_count_range();
        write_reg(REG_CELL_SIZE, 800);
        write_reg(REG_PAL_COUNT, 0);
        send_pixel(120, 0);
        wait_idle();
        write_reg(REG_PAL_COUNT, 1);
        send_pixel(60, 60);
        wait_idle();
        write_reg(REG_PAL_COUNT, 9);
        send_pixel(-200, 75);
        wait_idle();
        write_reg(REG_PAL_COUNT, 15);
        send_pixel(310, -400);
        wait_idle();
    endtask

    // The cell just below an axis shares an index with the second cell above it, as magnitudes are summed.
    task automatic test_negative_cells();
        write_reg(REG_PAL_COUNT, 8);
        send_pixel(-1, 0);
        send_pixel(-51, 0);
        send_pixel(50, 0);
        send_pixel(-49, -101);
        wait_idle();
    endtask

    task automatic apply_setting(input int kind);
        case (kind)
            0: begin
                write_reg(REG_CELL_SIZE, 160);
                write_reg(REG_COS_SIN, 64'h0000_4000);
                write_reg(REG_PAL_COUNT, 2);
                write_reg(REG_FILL_ALPHA, 0);
                write_palette('0, rand_word(), rand_word(), rand_word());
            end
            1: begin
                write_reg(REG_CELL_SIZE, 4800);
                write_reg(REG_COS_SIN, 64'hFFFF_FFFF_C000_0000);
                write_reg(REG_PAL_COUNT, 8);
                write_reg(REG_FILL_ALPHA, 255);
                write_palette('1, '1, '1, '1);
            end
            default: begin
                if ($urandom_range(3) == 0)
                    write_reg(REG_CELL_SIZE, rand_word());
                else
                    write_reg(REG_CELL_SIZE, PDATA_W'($urandom_range(4800, 160)));
                write_reg(REG_COS_SIN, rand_word());
                if ($urandom_range(4) == 0)
                    write_reg(REG_PAL_COUNT, PDATA_W'($urandom_range(15)));
                else
                    write_reg(REG_PAL_COUNT, PDATA_W'($urandom_range(8, 2)));
                write_reg(REG_FILL_ALPHA, rand_word());
                write_palette(rand_word(), rand_word(), rand_word(), rand_word());
            end
        endcase
    endtask

    task automatic test_random_stream(input int phase);
        for (int k = 0; k < SETTINGS_PER_PHASE; k++) begin
            if (phase == 0 && k == 0)
                apply_setting(0);
            else if (phase == 2 && k == SETTINGS_PER_PHASE - 1)
                apply_setting(1);
            else
                apply_setting(2);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
                send_pixel(rand_coord(), rand_coord());
            wait_idle();
        end
    endtask

    initial begin
        recv_idle_pct = 30;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_coordinate_extremes();
        test_zero_cell_size();
        test_palette_count_range();
        test_negative_cells();

        send_idle_pct = 11;
        recv_idle_pct = 61;
        test_random_stream(0);
        send_idle_pct = 61;
        recv_idle_pct = 11;
        test_random_stream(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(2);

        wait_idle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rcg_pkg.sv
src/rcg_floor_div.sv
src/rotated_checkerboard_color_generator.sv
src/rcg_checker.sv
test/tb_rotated_checkerboard_color_generator.sv
